/* rtl/iss_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed sequential search package
// Shared field widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package iss_pkg;

   // Field widths
   localparam int KeyWidth    = 32;
   localparam int ModeWidth   = 2;
   localparam int StatusWidth = 2;
   localparam int PosWidth    = 10;
   localparam int GroupWidth  = 11;

   typedef logic [ModeWidth-1:0]   mode_type;
   typedef logic [StatusWidth-1:0] status_type;
   typedef logic [PosWidth-1:0]    pos_type;
   typedef logic [GroupWidth-1:0]  group_type;
   typedef logic signed [KeyWidth-1:0] key_type;

   // Operation codes carried in req_tuser
   localparam mode_type ModeAppend = 2'd0;
   localparam mode_type ModeSearch = 2'd1;
   localparam mode_type ModeClear  = 2'd2;
   localparam mode_type ModeBad    = 2'd3;

   // Status codes carried in rsp_tuser
   localparam status_type StatusOk       = 2'd0;
   localparam status_type StatusNotFound = 2'd1;
   localparam status_type StatusFull     = 2'd2;
   localparam status_type StatusBadMode  = 2'd3;

   // Group size after reset
   localparam group_type GroupSizeReset = 11'd5;

endpackage

/* rtl/iss_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module iss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/indexed_sequential_search_unit.sv */
// Append, clear and bad-mode items, and searches of an empty table, load their
// result into the response register when taken. Search: a first-entry check
// on entry 0, a read per group leader, entry into the last group, then
// binary-search probes until a hit or a miss.
// One item is in work at a time; the key RAM's single read port sets the pace.
// Reset: entry count 0, group size 5; the key RAM is not cleared.
// ----------------------------------------------------------------------------
// Indexed sequential search unit
// Key table in RAM, filled by appends; searches walk group leaders, then
// binary-search inside the chosen group.
// ----------------------------------------------------------------------------
module indexed_sequential_search_unit
   import iss_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key (signed)
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] position, [15:10] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration
   input  logic        csr_we,
   input  logic [10:0] csr_wdata    // [10:0] group_size
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = ((CW > GroupWidth) ? CW : GroupWidth) + 1;
   localparam int PW = (AW > PosWidth) ? AW : PosWidth;

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIRST = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SCMP  = 3'd3;
   localparam logic [2:0] S_BIN   = 3'd4;
   localparam logic [2:0] S_BCMP  = 3'd5;

   logic [2:0]    state_ff, state_in;
   group_type     group_ff;
   logic [CW-1:0] count_ff, count_in;
   key_type       key_ff, key_in;
   logic [LW-1:0] lead_ff, lead_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] end_ff, end_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   pos_type       rsp_pos_ff, rsp_pos_in;

   logic          req_fire;
   logic          out_free;
   mode_type      req_mode;
   key_type       req_key;
   group_type     group_eff;
   logic [LW-1:0] group_ext;
   logic [CW-1:0] mid_calc;
   logic          ram_we;
   logic [AW-1:0] ram_rd_addr;
   logic [31:0]   ram_rd_data;
   key_type       rd_key;
   logic          done;
   status_type    done_status;
   logic [AW-1:0] done_addr;
   logic [PW-1:0] done_pos_wide;

   assign req_mode  = req_tuser;
   assign req_key   = $signed(req_tdata);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_tvalid && req_tready;
   assign group_eff = (group_ff == '0) ? GroupWidth'(1) : group_ff;
   assign group_ext = LW'(group_eff);
   assign rd_key    = $signed(ram_rd_data);
   assign mid_calc  = lo_ff + ((end_ff - lo_ff - CW'(1)) >> 1);
   assign ram_we    = req_fire && (req_mode == ModeAppend) &&
                      (count_ff < CW'(TABLE_DEPTH));

   // Key table
   iss_ram #(
      .WIDTH (KeyWidth),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer: pick read address, advance the search
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      key_in      = key_ff;
      lead_in     = lead_ff;
      lo_in       = lo_ff;
      end_in      = end_ff;
      mid_in      = mid_ff;
      ram_rd_addr = '0;
      done        = 1'b0;
      done_status = StatusOk;
      done_addr   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  ModeAppend: begin
                     done = 1'b1;
                     if (count_ff < CW'(TABLE_DEPTH)) begin
                        done_addr = count_ff[AW-1:0];
                        count_in  = count_ff + CW'(1);
                     end else begin
                        done_status = StatusFull;
                     end
                  end
                  ModeSearch: begin
                     if (count_ff == '0) begin
                        done        = 1'b1;
                        done_status = StatusNotFound;
                     end else begin
                        key_in   = req_key;
                        state_in = S_FIRST;
                     end
                  end
                  ModeClear: begin
                     done     = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     done        = 1'b1;
                     done_status = StatusBadMode;
                  end
               endcase
            end
         end
         S_FIRST: begin
            // Entry 0 was read; drop keys below the first leader
            if (key_ff < rd_key) begin
               done        = 1'b1;
               done_status = StatusNotFound;
               state_in    = S_IDLE;
            end else begin
               lead_in  = group_ext;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (lead_ff >= LW'(count_ff)) begin
               // Last group runs to the end of the table
               lo_in    = CW'(lead_ff - group_ext);
               end_in   = count_ff;
               state_in = S_BIN;
            end else begin
               ram_rd_addr = lead_ff[AW-1:0];
               state_in    = S_SCMP;
            end
         end
         S_SCMP: begin
            if (key_ff < rd_key) begin
               lo_in    = CW'(lead_ff - group_ext);
               end_in   = CW'(lead_ff);
               state_in = S_BIN;
            end else begin
               lead_in  = lead_ff + group_ext;
               state_in = S_SCAN;
            end
         end
         S_BIN: begin
            if (end_ff <= lo_ff) begin
               done        = 1'b1;
               done_status = StatusNotFound;
               state_in    = S_IDLE;
            end else begin
               mid_in      = mid_calc;
               ram_rd_addr = mid_calc[AW-1:0];
               state_in    = S_BCMP;
            end
         end
         S_BCMP: begin
            if (rd_key == key_ff) begin
               done      = 1'b1;
               done_addr = mid_ff[AW-1:0];
               state_in  = S_IDLE;
            end else if (rd_key > key_ff) begin
               end_in   = mid_ff;
               state_in = S_BIN;
            end else begin
               lo_in    = mid_ff + CW'(1);
               state_in = S_BIN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign done_pos_wide = PW'(done_addr);

   // Output register: load on completion, drop when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done_status;
         rsp_pos_in    = done_pos_wide[PosWidth-1:0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         group_ff     <= GroupSizeReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            group_ff <= csr_wdata;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      lead_ff       <= lead_in;
      lo_ff         <= lo_in;
      end_ff        <= end_in;
      mid_ff        <= mid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(16 - PosWidth){1'b0}}, rsp_pos_ff};

   // Entry count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // Probe address lies inside the live search window
   a_probe_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BCMP) |-> (mid_ff >= lo_ff) && (mid_ff < end_ff) &&
                               (mid_ff < count_ff))
      else $error("binary search probe outside window");

   // An accepted append to a non-full table grows the count by one
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == ModeAppend) && (count_ff < CW'(TABLE_DEPTH)))
      |=> (count_ff == $past(count_ff) + CW'(1)) && rsp_tvalid)
      else $error("append did not advance entry count");

   // No new item while a search is in work
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("item accepted during search");

endmodule
